### hw/rtl/rsi_pkg.sv
`timescale 1ns / 1ps
// Shared types and widths of the ray-sphere intersection block.
package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int T_W       = 31;
  localparam int A_W       = 64;
  localparam int H_W       = 66;
  localparam int LEN_W     = 66;
  localparam int C_W       = 67;
  // The discriminant of a real hit is bounded by |dir|^2 * r^2 * 2^FRAC_BITS.
  localparam int DISC_W    = A_W + COORD_W + FRAC_BITS;
  localparam int ROOT_W    = (DISC_W + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int NUM_W     = 67;
  localparam int MAG_W     = NUM_W - 1;
  localparam int DV_W      = A_W + T_W;
  localparam int DIV_N     = T_W + 1;
  localparam int MIDQ_DEPTH = 4;
  localparam int MIDQ_AW    = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t [2:0]     o;
    coord_t [2:0]     d;
    coord_t [2:0]     c;
    logic [31:0]      r2;
    logic [T_W-1:0]   lo;
    logic [T_W-1:0]   hi;
  } in_t;

  typedef struct packed {
    logic                   nohit;
    logic signed [H_W-1:0]  h;
    logic [A_W-1:0]         a;
    logic [T_W-1:0]         lo;
    logic [T_W-1:0]         hi;
    coord_t [2:0]           o;
    coord_t [2:0]           d;
  } ctx_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [DISC_W-1:0] disc;
  } mid_t;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] t;
    coord_t [2:0]   p;
  } res_t;

endpackage

### hw/rtl/rsi_front.sv
`timescale 1ns / 1ps
// Front pipeline: quadratic coefficients, discriminant and no-hit classification.
module rsi_front import rsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  in_t  in_i,
  output logic vld_o,
  output mid_t out_o
);

  localparam int PrdW = 132;

  typedef struct packed {
    coord_t [2:0]   o;
    coord_t [2:0]   d;
    logic [T_W-1:0] lo;
    logic [T_W-1:0] hi;
  } ray_t;

  logic                 f1_vld_q, f2_vld_q, f3_vld_q, f4_vld_q, f5_vld_q, f6_vld_q;
  ray_t                 f1_ray_q, f2_ray_q, f3_ray_q, f4_ray_q, f5_ray_q;
  logic signed [32:0]   f1_oc_q [3];
  logic [31:0]          f1_r2_q, f2_r2_q;
  logic [63:0]          f2_dd_q [3];
  logic [63:0]          f2_oo_q [3];
  logic signed [64:0]   f2_od_q [3];
  logic [A_W-1:0]       f3_a_q, f4_a_q, f5_a_q;
  logic signed [H_W-1:0] f3_h_q, f4_h_q, f5_h_q;
  logic signed [C_W-1:0] f3_c_q;
  logic [65:0]          f4_hll_q;
  logic [64:0]          f4_hlh_q, f4_all_q, f4_alh_q, f4_ahl_q, f4_ahh_q;
  logic [63:0]          f4_hhh_q;
  logic                 f4_cneg_q, f5_cneg_q;
  logic                 f4_zero_q, f5_zero_q;
  logic [PrdW-1:0]      f5_hsq_q, f5_ac_q;
  mid_t                 f6_q;

  logic [A_W-1:0]        a_d;
  logic [LEN_W-1:0]      len_d;
  logic signed [H_W-1:0] h_d;
  logic signed [C_W-1:0] c_d;
  logic [H_W-1:0]        hm;
  logic [C_W-1:0]        cm;
  logic [PrdW-1:0]       hsq_d, ac_d, disc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      f4_vld_q <= 1'b0;
      f5_vld_q <= 1'b0;
      f6_vld_q <= 1'b0;
    end else if (en_i) begin
      f1_vld_q <= vld_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
      f4_vld_q <= f3_vld_q;
      f5_vld_q <= f4_vld_q;
      f6_vld_q <= f5_vld_q;
    end
  end

  always_comb begin
    a_d   = f2_dd_q[0] + f2_dd_q[1] + f2_dd_q[2];
    len_d = LEN_W'(f2_oo_q[0]) + LEN_W'(f2_oo_q[1]) + LEN_W'(f2_oo_q[2]);
    h_d   = H_W'(f2_od_q[0]) + H_W'(f2_od_q[1]) + H_W'(f2_od_q[2]);
    c_d   = $signed({1'b0, len_d})
          - $signed({{(C_W - 32 - FRAC_BITS){1'b0}}, f2_r2_q, {FRAC_BITS{1'b0}}});
    hm    = f3_h_q[H_W-1] ? H_W'(-f3_h_q) : H_W'(f3_h_q);
    cm    = f3_c_q[C_W-1] ? C_W'(-f3_c_q) : C_W'(f3_c_q);
    hsq_d = (PrdW'(f4_hhh_q) << 66) + (PrdW'(f4_hlh_q) << 34) + PrdW'(f4_hll_q);
    ac_d  = (PrdW'(f4_ahh_q) << 65) + (PrdW'(f4_alh_q) << 33)
          + (PrdW'(f4_ahl_q) << 32) + PrdW'(f4_all_q);
    disc_d = f5_cneg_q ? (f5_hsq_q + f5_ac_q) : (f5_hsq_q - f5_ac_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_ray_q <= '{o: in_i.o, d: in_i.d, lo: in_i.lo, hi: in_i.hi};
      f1_r2_q  <= in_i.r2;
      for (int i = 0; i < 3; i++) begin
        f1_oc_q[i] <= $signed({in_i.o[i][31], in_i.o[i]}) - $signed({in_i.c[i][31], in_i.c[i]});
      end

      f2_ray_q <= f1_ray_q;
      f2_r2_q  <= f1_r2_q;
      for (int i = 0; i < 3; i++) begin
        f2_dd_q[i] <= 64'($signed(f1_ray_q.d[i]) * $signed(f1_ray_q.d[i]));
        f2_oo_q[i] <= 64'(f1_oc_q[i] * f1_oc_q[i]);
        f2_od_q[i] <= f1_oc_q[i] * $signed(f1_ray_q.d[i]);
      end

      f3_ray_q <= f2_ray_q;
      f3_a_q   <= a_d;
      f3_h_q   <= h_d;
      f3_c_q   <= c_d;

      // The wide square of h and the product a*c are split into partial products of about 33 bits.
      f4_ray_q  <= f3_ray_q;
      f4_a_q    <= f3_a_q;
      f4_h_q    <= f3_h_q;
      f4_zero_q <= (f3_a_q == '0);
      f4_cneg_q <= f3_c_q[C_W-1];
      f4_hll_q  <= hm[32:0] * hm[32:0];
      f4_hlh_q  <= hm[32:0] * hm[64:33];
      f4_hhh_q  <= hm[64:33] * hm[64:33];
      f4_all_q  <= f3_a_q[31:0] * cm[32:0];
      f4_alh_q  <= f3_a_q[31:0] * cm[65:33];
      f4_ahl_q  <= f3_a_q[63:32] * cm[32:0];
      f4_ahh_q  <= f3_a_q[63:32] * cm[65:33];

      f5_ray_q  <= f4_ray_q;
      f5_a_q    <= f4_a_q;
      f5_h_q    <= f4_h_q;
      f5_zero_q <= f4_zero_q;
      f5_cneg_q <= f4_cneg_q;
      f5_hsq_q  <= hsq_d;
      f5_ac_q   <= ac_d;

      f6_q.ctx.nohit <= f5_zero_q | disc_d[PrdW-1];
      f6_q.ctx.h     <= f5_h_q;
      f6_q.ctx.a     <= f5_a_q;
      f6_q.ctx.lo    <= f5_ray_q.lo;
      f6_q.ctx.hi    <= f5_ray_q.hi;
      f6_q.ctx.o     <= f5_ray_q.o;
      f6_q.ctx.d     <= f5_ray_q.d;
      f6_q.disc      <= disc_d[DISC_W-1:0];
    end
  end

  assign vld_o = f6_vld_q;
  assign out_o = f6_q;

endmodule

### hw/rtl/rsi_queue.sv
`timescale 1ns / 1ps
// Short queue that decouples the front pipeline from the back pipeline.
module rsi_queue import rsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  mid_t item_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output mid_t item_o
);

  mid_t               mem_q [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0] wptr_q, rptr_q;
  logic [MIDQ_AW:0]   cnt_q;
  logic               wr, rd;

  assign full_o  = (cnt_q == (MIDQ_AW + 1)'(MIDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= item_i;
  end

endmodule

### hw/rtl/rsi_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt import rsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  ctx_t              ctx_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output ctx_t              ctx_o
);

  localparam int RemW = ROOT_W + 2;

  logic              vld_q  [ROOT_W];
  logic [RAD_W-1:0]  x_q    [ROOT_W];
  logic [RemW-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  ctx_t              ctx_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic              v_in;
    logic [RAD_W-1:0]  x_in;
    logic [RemW-1:0]   rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    ctx_t              ctx_in;

    if (s == 0) begin : g_first
      assign v_in    = vld_i;
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctx_in  = ctx_i;
    end else begin : g_next
      assign v_in    = vld_q[s-1];
      assign x_in    = x_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign ctx_in  = ctx_q[s-1];
    end

    // The partial remainder never exceeds twice the partial root, so its low bits suffice.
    assign rem_sh = {rem_in[ROOT_W-1:0], x_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s] <= 1'b0;
      else if (en_i) vld_q[s] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]   <= x_in << 2;
        ctx_q[s] <= ctx_in;
        if (rem_sh >= trial) begin
          rem_q[s]  <= rem_sh - trial;
          root_q[s] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[s]  <= rem_sh;
          root_q[s] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign ctx_o  = ctx_q[ROOT_W-1];

endmodule

### hw/rtl/rsi_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for one root, with a quotient overflow flag.
module rsi_div import rsi_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [A_W-1:0]   den_i,
  output logic [T_W-1:0]   q_o,
  output logic             ovf_o
);

  logic [DV_W-1:0] rem_q [DIV_N];
  logic [A_W-1:0]  den_q [DIV_N];
  logic [T_W-1:0]  q_q   [DIV_N];
  logic            ovf_q [DIV_N];

  // Entry stage: a quotient of 2^T_W or more can never fall inside the interval.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DV_W'(mag_i) << FRAC_BITS;
      den_q[0] <= den_i;
      q_q[0]   <= '0;
      ovf_q[0] <= (DV_W'(mag_i) << FRAC_BITS) >= (DV_W'(den_i) << T_W);
    end
  end

  for (genvar j = 1; j < DIV_N; j++) begin : g_stage
    localparam int K = T_W - j;
    logic [DV_W-1:0] sub;

    assign sub = DV_W'(den_q[j-1]) << K;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        if (rem_q[j-1] >= sub) begin
          rem_q[j] <= rem_q[j-1] - sub;
          q_q[j]   <= q_q[j-1] | (T_W'(1) << K);
        end else begin
          rem_q[j] <= rem_q[j-1];
          q_q[j]   <= q_q[j-1];
        end
      end
    end
  end

  assign q_o   = q_q[DIV_N-1];
  assign ovf_o = ovf_q[DIV_N-1];

endmodule

### hw/rtl/rsi_back.sv
`timescale 1ns / 1ps
// Back pipeline: square root, both root divisions, interval test and hit point.
module rsi_back import rsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_vld_i,
  input  mid_t in_i,
  output logic out_vld_o,
  output res_t out_o
);

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  ctx_t              sq_ctx;

  logic signed [NUM_W-1:0] hx, rx, near_d, far_d;

  logic             b1_vld_q;
  ctx_t             b1_ctx_q;
  logic [MAG_W-1:0] b1_nmag_q, b1_fmag_q;
  logic             b1_nneg_q, b1_fneg_q;

  logic           dl_vld_q  [DIV_N];
  ctx_t           dl_ctx_q  [DIV_N];
  logic           dl_nneg_q [DIV_N];
  logic           dl_fneg_q [DIV_N];

  logic [T_W-1:0] qn, qf;
  logic           novf, fovf;
  logic           near_ok, far_ok, hit_d;
  ctx_t           sel_ctx;

  logic           s_vld_q, s_hit_q;
  logic [T_W-1:0] s_t_q;
  coord_t [2:0]   s_o_q, s_d_q;

  logic               pr_vld_q, pr_hit_q;
  logic [T_W-1:0]     pr_t_q;
  coord_t [2:0]       pr_o_q;
  logic signed [63:0] pr_q [3];

  logic signed [63:0] sum_d [3];
  coord_t [2:0]       pt_d;

  logic out_vld_q;
  res_t out_q;

  rsi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (in_vld_i),
    .rad_i  (RAD_W'(in_i.disc)),
    .ctx_i  (in_i.ctx),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .ctx_o  (sq_ctx)
  );

  always_comb begin
    hx     = $signed({{(NUM_W - H_W){sq_ctx.h[H_W-1]}}, sq_ctx.h});
    rx     = $signed({{(NUM_W - ROOT_W){1'b0}}, sq_root});
    near_d = -hx - rx;
    far_d  = -hx + rx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      s_vld_q   <= 1'b0;
      pr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      b1_vld_q  <= sq_vld;
      s_vld_q   <= dl_vld_q[DIV_N-1];
      pr_vld_q  <= s_vld_q;
      out_vld_q <= pr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_ctx_q  <= sq_ctx;
      b1_nneg_q <= near_d[NUM_W-1];
      b1_fneg_q <= far_d[NUM_W-1];
      b1_nmag_q <= near_d[MAG_W-1:0];
      b1_fmag_q <= far_d[MAG_W-1:0];
    end
  end

  rsi_div u_div_near (
    .clk_i (clk_i),
    .en_i  (en_i),
    .mag_i (b1_nmag_q),
    .den_i (b1_ctx_q.a),
    .q_o   (qn),
    .ovf_o (novf)
  );

  rsi_div u_div_far (
    .clk_i (clk_i),
    .en_i  (en_i),
    .mag_i (b1_fmag_q),
    .den_i (b1_ctx_q.a),
    .q_o   (qf),
    .ovf_o (fovf)
  );

  // Side information travels beside the dividers.
  for (genvar i = 0; i < DIV_N; i++) begin : g_dly
    logic v_in, nn_in, fn_in;
    ctx_t c_in;

    if (i == 0) begin : g_first
      assign v_in  = b1_vld_q;
      assign c_in  = b1_ctx_q;
      assign nn_in = b1_nneg_q;
      assign fn_in = b1_fneg_q;
    end else begin : g_next
      assign v_in  = dl_vld_q[i-1];
      assign c_in  = dl_ctx_q[i-1];
      assign nn_in = dl_nneg_q[i-1];
      assign fn_in = dl_fneg_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dl_vld_q[i] <= 1'b0;
      else if (en_i) dl_vld_q[i] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_ctx_q[i]  <= c_in;
        dl_nneg_q[i] <= nn_in;
        dl_fneg_q[i] <= fn_in;
      end
    end
  end

  always_comb begin
    sel_ctx = dl_ctx_q[DIV_N-1];
    near_ok = !dl_nneg_q[DIV_N-1] && !novf && (qn >= sel_ctx.lo) && (qn <= sel_ctx.hi);
    far_ok  = !dl_fneg_q[DIV_N-1] && !fovf && (qf >= sel_ctx.lo) && (qf <= sel_ctx.hi);
    hit_d   = !sel_ctx.nohit && (near_ok || far_ok);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_hit_q <= hit_d;
      s_t_q   <= near_ok ? qn : qf;
      s_o_q   <= sel_ctx.o;
      s_d_q   <= sel_ctx.d;

      pr_hit_q <= s_hit_q;
      pr_t_q   <= s_t_q;
      pr_o_q   <= s_o_q;
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= $signed({1'b0, s_t_q}) * $signed(s_d_q[i]);
      end

      out_q.hit <= pr_hit_q;
      out_q.t   <= pr_hit_q ? pr_t_q : '0;
      out_q.p   <= pr_hit_q ? pt_d : '0;
    end
  end

  // Arithmetic shift gives the floor of the scaled product; then saturate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = (pr_q[i] >>> FRAC_BITS) + $signed({{32{pr_o_q[i][31]}}, pr_o_q[i]});
      if (sum_d[i] > 64'sd2147483647) pt_d[i] = 32'sh7FFF_FFFF;
      else if (sum_d[i] < -64'sd2147483648) pt_d[i] = 32'sh8000_0000;
      else pt_d[i] = sum_d[i][31:0];
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

endmodule

### hw/rtl/ray_sphere_intersection_top.sv
`timescale 1ns / 1ps
// Top level of the ray-sphere intersection block with its result queue.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------------
//   request  | push, full       | origin, dir, center xyz, radius_squared, t_low/high
//   result   | empty, pop       | hit, t_hit, point xyz
//
// One request enters per cycle and one result leaves per cycle when nothing stalls.
// The back pipeline has 56 square root stages and 32 divider stages at 16 fraction bits.
// Reset clears all valid bits and queue pointers; there is no clearing pass.
// A full result queue stalls the back pipeline, which fills the middle queue,
// which then raises full and holds the front pipeline.
module ray_sphere_intersection_top import rsi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  logic [31:0]  origin_x_i,
  input  logic [31:0]  origin_y_i,
  input  logic [31:0]  origin_z_i,
  input  logic [31:0]  dir_x_i,
  input  logic [31:0]  dir_y_i,
  input  logic [31:0]  dir_z_i,
  input  logic [31:0]  center_x_i,
  input  logic [31:0]  center_y_i,
  input  logic [31:0]  center_z_i,
  input  logic [31:0]  radius_squared_i,
  input  logic [30:0]  t_low_i,
  input  logic [30:0]  t_high_i,
  output logic         empty,
  input  logic         pop,
  output logic         hit_o,
  output logic [30:0]  t_hit_o,
  output logic [31:0]  point_x_o,
  output logic [31:0]  point_y_o,
  output logic [31:0]  point_z_o
);

  in_t  req;
  logic fr_vld;
  mid_t fr_item;
  logic mq_full, mq_empty, mq_pop;
  mid_t mq_item;
  logic bk_en, bk_vld, bk_push;
  res_t bk_res;

  res_t       oq_q [2];
  logic       oq_wptr_q, oq_rptr_q;
  logic [1:0] oq_cnt_q;
  logic       oq_full, oq_pop;

  assign req.o  = {origin_z_i, origin_y_i, origin_x_i};
  assign req.d  = {dir_z_i, dir_y_i, dir_x_i};
  assign req.c  = {center_z_i, center_y_i, center_x_i};
  assign req.r2 = radius_squared_i;
  assign req.lo = t_low_i;
  assign req.hi = t_high_i;

  assign full = mq_full;

  rsi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (!mq_full),
    .vld_i  (push),
    .in_i   (req),
    .vld_o  (fr_vld),
    .out_o  (fr_item)
  );

  rsi_queue u_midq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_vld),
    .item_i  (fr_item),
    .pop_i   (mq_pop),
    .full_o  (mq_full),
    .empty_o (mq_empty),
    .item_o  (mq_item)
  );

  assign bk_en  = !oq_full;
  assign mq_pop = bk_en && !mq_empty;

  rsi_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (bk_en),
    .in_vld_i  (!mq_empty),
    .in_i      (mq_item),
    .out_vld_o (bk_vld),
    .out_o     (bk_res)
  );

  // Two-entry result queue.
  assign oq_full = (oq_cnt_q == 2'd2);
  assign empty   = (oq_cnt_q == 2'd0);
  assign bk_push = bk_vld && bk_en;
  assign oq_pop  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wptr_q <= 1'b0;
      oq_rptr_q <= 1'b0;
      oq_cnt_q  <= 2'd0;
    end else begin
      if (bk_push) oq_wptr_q <= !oq_wptr_q;
      if (oq_pop) oq_rptr_q <= !oq_rptr_q;
      if (bk_push && !oq_pop) oq_cnt_q <= oq_cnt_q + 2'd1;
      else if (oq_pop && !bk_push) oq_cnt_q <= oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bk_push) oq_q[oq_wptr_q] <= bk_res;
  end

  assign hit_o     = oq_q[oq_rptr_q].hit;
  assign t_hit_o   = oq_q[oq_rptr_q].t;
  assign point_x_o = oq_q[oq_rptr_q].p[0];
  assign point_y_o = oq_q[oq_rptr_q].p[1];
  assign point_z_o = oq_q[oq_rptr_q].p[2];

`ifndef NO_ASSERTIONS
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_push |=> !empty)
    else $error("result pushed by the back pipeline did not reach the result queue");

  a_midq_holds_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mq_full && !mq_pop) |=> mq_full)
    else $error("middle queue left full state without a pop");

  a_oq_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oq_cnt_q == 2'd1 && oq_pop && !bk_push) |=> empty)
    else $error("result queue not empty after its last result was taken");
`endif

endmodule

### sim/ray_sphere_intersection_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ray-sphere intersection block.
module ray_sphere_intersection_top_tb;
  import rsi_pkg::*;

  localparam int WIDE = 192;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_RAYS = 1100;

  typedef logic signed [WIDE-1:0] wide_t;

  class ray_scoreboard;
    res_t hits_due[$];
    int   errors = 0;

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    // Exact wide-integer form of the half-b quadratic, then the fixed-point hit point.
    function res_t trace_ray(in_t q);
      wide_t oc, dv, a, h, lenoc, c, disc, root, cand, num, tq;
      logic signed [63:0] tt, prod, sum;
      res_t r;
      bit found;
      r = '0;
      a = 0;
      h = 0;
      lenoc = 0;
      found = 0;
      for (int k = 0; k < 3; k++) begin
        oc = wide_t'($signed(q.o[k])) - wide_t'($signed(q.c[k]));
        dv = wide_t'($signed(q.d[k]));
        a = a + dv * dv;
        h = h + oc * dv;
        lenoc = lenoc + oc * oc;
      end
      if (a == 0) return r;
      c = lenoc - ($signed({160'd0, q.r2}) <<< FRAC_BITS);
      disc = h * h - a * c;
      if (disc < 0) return r;
      root = 0;
      for (int i = 67; i >= 0; i--) begin
        cand = root | (wide_t'(1) <<< i);
        if (cand * cand <= disc) root = cand;
      end
      // The near root is tried first, then the far one.
      for (int n = 0; n < 2 && !found; n++) begin
        num = (n == 0) ? -h - root : -h + root;
        if (num >= 0) begin
          tq = (num <<< FRAC_BITS) / a;
          if (tq >= $signed({161'd0, q.lo}) && tq <= $signed({161'd0, q.hi})) found = 1;
        end
      end
      if (!found) return r;
      r.hit = 1'b1;
      r.t = tq[T_W-1:0];
      tt = tq[63:0];
      for (int k = 0; k < 3; k++) begin
        prod = tt * 64'($signed(q.d[k]));
        sum = 64'($signed(q.o[k])) + (prod >>> FRAC_BITS);
        if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
        if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
        r.p[k] = sum[31:0];
      end
      return r;
    endfunction

    function void note(in_t q);
      hits_due.push_back(trace_ray(q));
    endfunction

    function void check(res_t got);
      res_t exp_r;
      if (hits_due.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp_r = hits_due.pop_front();
      if (got.hit !== exp_r.hit)
        report($sformatf("hit got %0b want %0b", got.hit, exp_r.hit));
      if (got.t !== exp_r.t)
        report($sformatf("t_hit got %h want %h", got.t, exp_r.t));
      for (int k = 0; k < 3; k++)
        if (got.p[k] !== exp_r.p[k])
          report($sformatf("point[%0d] got %h want %h", k, got.p[k], exp_r.p[k]));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push, full, empty, pop;
  in_t  ray;
  logic hit_o;
  logic [30:0] t_hit_o;
  logic [31:0] point_x_o, point_y_o, point_z_o;
  bit   calm = 0;
  int   cycles = 0;
  ray_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  ray_sphere_intersection_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .origin_x_i(ray.o[0]), .origin_y_i(ray.o[1]), .origin_z_i(ray.o[2]),
    .dir_x_i(ray.d[0]), .dir_y_i(ray.d[1]), .dir_z_i(ray.d[2]),
    .center_x_i(ray.c[0]), .center_y_i(ray.c[1]), .center_z_i(ray.c[2]),
    .radius_squared_i(ray.r2), .t_low_i(ray.lo), .t_high_i(ray.hi),
    .empty(empty), .pop(pop), .hit_o(hit_o), .t_hit_o(t_hit_o),
    .point_x_o(point_x_o), .point_y_o(point_y_o), .point_z_o(point_z_o)
  );

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (push && !full) sb.note(ray);
      if (pop && !empty) begin
        got.hit = hit_o;
        got.t = t_hit_o;
        got.p[0] = point_x_o;
        got.p[1] = point_y_o;
        got.p[2] = point_z_o;
        sb.check(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop <= (!calm && $urandom_range(99) < 36) ? 1'b0 : 1'b1;
    end
  end

  function automatic logic [31:0] near_val(int bits);
    return 32'($signed(($urandom & ((32'd1 << bits) - 1)) - (32'd1 << (bits - 1))));
  endfunction

  task automatic send_ray(in_t q);
    while (!calm && $urandom_range(99) < 36) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    ray <= q;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic directed_ray(logic [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
                              logic [31:0] r2, logic [30:0] lo, hi);
    in_t q;
    q.o[0] = ox; q.o[1] = oy; q.o[2] = oz;
    q.d[0] = dx; q.d[1] = dy; q.d[2] = dz;
    q.c[0] = cx; q.c[1] = cy; q.c[2] = cz;
    q.r2 = r2; q.lo = lo; q.hi = hi;
    send_ray(q);
  endtask

  // Most rays aim at a sphere near their origin so that real hits dominate.
  function automatic in_t aimed_ray();
    in_t q;
    int bits, sh;
    logic [31:0] rad;
    bits = $urandom_range(18, 23);
    sh = $urandom_range(0, 4);
    for (int k = 0; k < 3; k++) begin
      q.c[k] = near_val(30);
      q.o[k] = q.c[k] + near_val(bits);
      q.d[k] = ($signed(q.c[k] - q.o[k]) >>> sh) + near_val(bits - 3);
    end
    rad = $urandom_range(1, 1 << (bits - 1));
    q.r2 = 32'((64'(rad) * rad) >> FRAC_BITS);
    q.lo = ($urandom_range(3) == 0) ? 31'($urandom_range(1 << 17)) : 31'd0;
    q.hi = ($urandom_range(3) == 0) ? 31'($urandom) : 31'h7FFF_FFFF;
    return q;
  endfunction

  function automatic in_t noise_ray();
    in_t q;
    for (int k = 0; k < 3; k++) begin
      q.o[k] = $urandom;
      q.d[k] = $urandom;
      q.c[k] = $urandom;
    end
    q.r2 = $urandom;
    q.lo = 31'($urandom);
    q.hi = 31'($urandom);
    return q;
  endfunction

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    ray = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Zero direction, then a sphere far off the ray (negative discriminant).
    directed_ray(0, 0, 0, 0, 0, 0, 32'h0005_0000, 0, 0, 32'h0001_0000, 0, 31'h7FFF_FFFF);
    directed_ray(0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0064_0000, 0, 32'h0001_0000,
                 0, 31'h7FFF_FFFF);
    // Plain hit in front, origin inside the sphere, sphere behind the ray.
    directed_ray(0, 0, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0, 32'h0004_0000,
                 0, 31'h7FFF_FFFF);
    directed_ray(32'h000A_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0,
                 32'h0004_0000, 0, 31'h7FFF_FFFF);
    directed_ray(0, 0, 0, 32'hFFFF_0000, 0, 0, 32'h000A_0000, 0, 0, 32'h0004_0000,
                 0, 31'h7FFF_FFFF);
    // Empty interval, and an interval that holds only the exact near root.
    directed_ray(0, 0, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0, 32'h0004_0000,
                 31'h0009_0000, 31'h0001_0000);
    directed_ray(0, 0, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0, 32'h0004_0000,
                 31'h0008_0000, 31'h0008_0000);
    // Tangent ray and a zero radius.
    directed_ray(0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0,
                 32'h0004_0000, 0, 31'h7FFF_FFFF);
    directed_ray(0, 0, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0, 0, 0, 31'h7FFF_FFFF);
    // Hit point overflows both ways.
    directed_ray(32'h7FFF_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 31'h7FFF_FFFF);
    // Field extremes.
    directed_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    directed_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 0, 31'h7FFF_FFFF);
    directed_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);

    for (int n = 0; n < RANDOM_RAYS; n++) begin
      calm = (n >= 200 && n < 400);
      if (n == 700) begin
        push <= 1'b0;
        while (sb.hits_due.size() != 0) @(negedge clk_i);
      end
      send_ray(($urandom_range(99) < 20) ? noise_ray() : aimed_ray());
    end
    calm = 0;
    push <= 1'b0;

    while (sb.hits_due.size() != 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_front.sv
hw/rtl/rsi_queue.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_div.sv
hw/rtl/rsi_back.sv
hw/rtl/ray_sphere_intersection_top.sv
sim/ray_sphere_intersection_top_tb.sv
